### hdl/aec_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the easing curve unit.
// No dependencies; every other file imports this package.
package aec_pkg;

    localparam int FRAC_BITS = 16;
    localparam int T_W       = 18;
    localparam int KIND_W    = 4;
    localparam int OUT_W     = 20;
    localparam int S_DATA_W  = 24;
    localparam int M_DATA_W  = 24;

    // phase shift that turns Q2.16 progress into a 32-bit half-turn phase
    localparam int PH_SH     = 31 - FRAC_BITS;
    // elastic exponent shift is K_BASE - ip
    localparam int K_BASE    = 60 - FRAC_BITS;
    localparam int IP_MIN    = K_BASE - 62;

    localparam logic [31:0] Q30_ONE     = 32'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;
    localparam logic signed [18:0] T_ONE = 19'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] OUT_MAX = 64'sd524287;
    localparam logic signed [63:0] OUT_MIN = -64'sd524288;

    localparam logic [63:0] RECIP3_W = (64'd4294967296 + 64'd2) / 64'd3;
    localparam logic [32:0] RECIP3   = RECIP3_W[32:0];

    typedef enum logic [KIND_W-1:0] {
        K_NONE, K_ONE, K_SINE, K_QUAD, K_ELASTIC,
        K_BOUNCE1, K_BOUNCE2, K_BOUNCE4, K_BOUNCE8,
        K_PULSE1, K_PULSE8
    } kind_t;

    // payload that rides along every pipeline stage
    typedef struct packed {
        logic signed [T_W-1:0] t;
        logic [KIND_W-1:0]     kind;
        logic [31:0]           ph;     // sine phase, 2^32 = one turn
        logic signed [5:0]     ip;     // integer part of -10t
        logic [31:0]           expv;   // 2^frac in Q30
        logic [30:0]           sx;     // folded sine argument, Q30
        logic [1:0]            quad;
    } side_t;

    function automatic logic is_wave(input logic [KIND_W-1:0] k);
        case (kind_t'(k))
            K_BOUNCE1, K_BOUNCE2, K_BOUNCE4, K_BOUNCE8,
            K_PULSE1, K_PULSE8: is_wave = 1'b1;
            default:            is_wave = 1'b0;
        endcase
    endfunction

    function automatic logic is_pulse(input logic [KIND_W-1:0] k);
        case (kind_t'(k))
            K_PULSE1, K_PULSE8: is_pulse = 1'b1;
            default:            is_pulse = 1'b0;
        endcase
    endfunction

    // log2 of the half-cycle count
    function automatic logic [1:0] wave_sh(input logic [KIND_W-1:0] k);
        case (kind_t'(k))
            K_BOUNCE2: wave_sh = 2'd1;
            K_BOUNCE4: wave_sh = 2'd2;
            K_BOUNCE8,
            K_PULSE8:  wave_sh = 2'd3;
            default:   wave_sh = 2'd0;
        endcase
    endfunction

endpackage

### hdl/animation_easing_curve_unit.sv
`timescale 1ns / 1ps
// Easing curve evaluator, top level.
// Uses aec_pkg, aec_front, aec_poly_step, aec_sine, aec_post.
//
//  channel  | ports               | tdata / tuser
//  ---------+---------------------+-----------------------------------------
//  input    | s_tvalid/tready     | tdata[17:0] t_value, tuser[3:0] easing_kind
//  result   | m_tvalid/tready     | tdata[19:0] eased_value
//
// One request per cycle while the output is not stalled; 3 front stages, ten 3-stage
// 2^x series steps, 18 sine stages (five 3-stage series steps), 4 back stages.
// Synchronous active-low reset clears only the valid bits.
// The whole pipe advances when the output register is empty or taken; a
// stall at the output holds every stage and s_tready drops with it.
module animation_easing_curve_unit
    import aec_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [17:0] t_value
    input  logic [KIND_W-1:0]   s_tuser,   // [3:0] easing_kind
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // [19:0] eased_value
);

    localparam int NEXP = 10;

    logic en;
    logic [OUT_W-1:0] eased;

    logic        ev [0:NEXP];
    logic [31:0] ex [0:NEXP];
    logic [31:0] ep [0:NEXP];
    side_t       es [0:NEXP];

    side_t              sine_in;
    logic               sine_v;
    logic signed [31:0] sin_val;
    side_t              sine_side;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    aec_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_tvalid),
        .t_value     (signed'(s_tdata[T_W-1:0])),
        .easing_kind (s_tuser),
        .out_valid   (ev[0]),
        .exp_arg     (ex[0]),
        .side_out    (es[0])
    );

    assign ep[0] = Q30_ONE;

    // 2^f series, divisors 10 down to 1
    for (genvar i = 0; i < NEXP; i++) begin : g_exp
        aec_poly_step #(.D(NEXP - i), .ADD(1'b1)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (ev[i]),
            .x_in      (ex[i]),
            .p_in      (ep[i]),
            .side_in   (es[i]),
            .out_valid (ev[i+1]),
            .x_out     (ex[i+1]),
            .p_out     (ep[i+1]),
            .side_out  (es[i+1])
        );
    end

    always_comb begin
        sine_in      = es[NEXP];
        sine_in.expv = ep[NEXP];
    end

    aec_sine u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (ev[NEXP]),
        .side_in   (sine_in),
        .out_valid (sine_v),
        .sin_q30   (sin_val),
        .side_out  (sine_side)
    );

    aec_post u_post (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (sine_v),
        .side_in     (sine_side),
        .sin_q30     (sin_val),
        .out_valid   (m_tvalid),
        .eased_value (eased)
    );

    assign m_tdata = {(M_DATA_W - OUT_W)'(0), eased};

    ap_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("request taken while output stalled");

endmodule

### hdl/aec_poly_step.sv
`timescale 1ns / 1ps
// One Horner step of a Q30 series: p' = ONE +/- floor(((x*p)>>30) / D).
// Three register stages; uses aec_pkg.
module aec_poly_step
    import aec_pkg::*;
#(
    parameter int D   = 1,
    parameter bit ADD = 1'b1
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        en,
    input  logic        in_valid,
    input  logic [31:0] x_in,
    input  logic [31:0] p_in,
    input  side_t       side_in,
    output logic        out_valid,
    output logic [31:0] x_out,
    output logic [31:0] p_out,
    output side_t       side_out
);

    localparam logic [63:0] RECIP_W = (64'd4294967296 + 64'(D) - 64'd1) / 64'(D);
    localparam logic [32:0] RECIP   = RECIP_W[32:0];
    localparam logic [6:0]  DIV     = 7'(D);

    logic [2:0]  vld_reg;
    logic [63:0] prod_a_reg;
    logic [31:0] x_a_reg, x_b_reg, x_c_reg;
    side_t       side_a_reg, side_b_reg, side_c_reg;
    logic [31:0] v_b_reg, est_b_reg, p_c_reg;

    logic [31:0] v_a;
    logic [64:0] est_prod;
    logic [38:0] back;
    logic [31:0] q;
    logic [31:0] p_next;

    assign v_a      = prod_a_reg[61:30];
    // estimate is exact or one too high
    assign est_prod = 65'(v_a) * 65'(RECIP);
    assign back     = 39'(est_b_reg) * 39'(DIV);
    assign q        = (back > 39'(v_b_reg)) ? est_b_reg - 32'd1 : est_b_reg;
    assign p_next   = ADD ? Q30_ONE + q : Q30_ONE - q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_a_reg <= 64'(x_in) * 64'(p_in);
            x_a_reg    <= x_in;
            side_a_reg <= side_in;
            v_b_reg    <= v_a;
            est_b_reg  <= est_prod[63:32];
            x_b_reg    <= x_a_reg;
            side_b_reg <= side_a_reg;
            p_c_reg    <= p_next;
            x_c_reg    <= x_b_reg;
            side_c_reg <= side_b_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign x_out     = x_c_reg;
    assign p_out     = p_c_reg;
    assign side_out  = side_c_reg;

endmodule

### hdl/aec_front.sv
`timescale 1ns / 1ps
// Front end: input register, elastic exponent split and phase selection,
// first product of the 2^x series. Three stages; uses aec_pkg.
module aec_front
    import aec_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [T_W-1:0] t_value,
    input  logic [KIND_W-1:0]     easing_kind,
    output logic                  out_valid,
    output logic [31:0]           exp_arg,
    output side_t                 side_out
);

    localparam logic signed [24:0] N_OFS = 25'sd3 <<< FRAC_BITS;

    logic [2:0] vld_reg;

    logic signed [T_W-1:0] t1_reg, t2_reg;
    logic [KIND_W-1:0]     kind1_reg, kind2_reg;
    logic signed [5:0]     ip2_reg;
    logic [15:0]           fb2_reg;
    logic [22:0]           absn2_reg;
    logic                  neg2_reg;
    logic [55:0]           prod3_2_reg;
    logic [60:0]           prode_3_reg;
    side_t                 side3_reg;

    logic signed [21:0] e;
    logic signed [24:0] n;
    logic [22:0]        absn;
    logic [22:0]        est3;
    logic [24:0]        back3;
    logic [22:0]        q3;
    logic [35:0]        qq;
    logic [31:0]        ph_el;
    logic [31:0]        ph;
    side_t              side_next;

    assign e    = -(22'(t1_reg) * 22'sd10);
    assign n    = 25'(t1_reg) * 25'sd40 - N_OFS;
    assign absn = n[24] ? 23'(-n) : 23'(n);

    // elastic phase: trunc(n * 2^14 / 3) = sign * (|n|*5461 + |n|/3)
    assign est3  = prod3_2_reg[54:32];
    assign back3 = 25'(est3) * 25'd3;
    assign q3    = (back3 > 25'(absn2_reg)) ? est3 - 23'd1 : est3;
    assign qq    = 36'(absn2_reg) * 36'd5461 + 36'(q3);
    assign ph_el = neg2_reg ? -qq[31:0] : qq[31:0];

    always_comb begin
        case (kind_t'(kind2_reg))
            K_SINE:    ph = (32'(t2_reg) << PH_SH) + Q30_ONE;
            K_ELASTIC: ph = ph_el;
            default:   ph = 32'(t2_reg) << (5'(PH_SH) + 5'(wave_sh(kind2_reg)));
        endcase
        side_next      = '0;
        side_next.t    = t2_reg;
        side_next.kind = kind2_reg;
        side_next.ph   = ph;
        side_next.ip   = ip2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg      <= t_value;
            kind1_reg   <= easing_kind;
            t2_reg      <= t1_reg;
            kind2_reg   <= kind1_reg;
            ip2_reg     <= e[21:16];
            fb2_reg     <= e[15:0];
            absn2_reg   <= absn;
            neg2_reg    <= n[24];
            prod3_2_reg <= 56'(absn) * 56'(RECIP3);
            side3_reg   <= side_next;
            prode_3_reg <= 61'({fb2_reg, 14'd0}) * 61'(LN2_Q30);
        end
    end

    assign out_valid = vld_reg[2];
    assign exp_arg   = 32'(prode_3_reg[59:30]);
    assign side_out  = side3_reg;

endmodule

### hdl/aec_sine.sv
`timescale 1ns / 1ps
// Sine of a 32-bit phase in Q30: quadrant fold, odd series, sign.
// Eighteen stages; uses aec_pkg and aec_poly_step.
module aec_sine
    import aec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  side_t              side_in,
    output logic               out_valid,
    output logic signed [31:0] sin_q30,
    output side_t              side_out
);

    localparam int NSTEP = 5;
    localparam int SIN_DIVS [0:NSTEP-1] = '{110, 72, 42, 20, 6};

    logic [2:0]  vld_reg;    // fold, square, final product
    logic [61:0] prod1_reg, prod2_reg, prod3_reg;
    side_t       side1_reg, side2_reg, side3_reg;

    logic [30:0] f;
    logic [30:0] x;
    side_t       side1_next, side2_next;

    logic        cv   [0:NSTEP];
    logic [31:0] cx   [0:NSTEP];
    logic [31:0] cp   [0:NSTEP];
    side_t       cs   [0:NSTEP];

    always_comb begin
        f = side_in.ph[30] ? 31'(Q30_ONE) - {1'b0, side_in.ph[29:0]}
                           : {1'b0, side_in.ph[29:0]};
        side1_next      = side_in;
        side1_next.quad = side_in.ph[31:30];
        x = prod1_reg[60:30];
        side2_next      = side1_reg;
        side2_next.sx   = x;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {cv[NSTEP], vld_reg[0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod1_reg <= 62'(f) * 62'(HALF_PI_Q30);
            side1_reg <= side1_next;
            prod2_reg <= 62'(x) * 62'(x);
            side2_reg <= side2_next;
            prod3_reg <= 62'(cs[NSTEP].sx) * 62'(cp[NSTEP]);
            side3_reg <= cs[NSTEP];
        end
    end

    assign cv[0] = vld_reg[1];
    assign cx[0] = prod2_reg[61:30];
    assign cp[0] = Q30_ONE;
    assign cs[0] = side2_reg;

    for (genvar i = 0; i < NSTEP; i++) begin : g_step
        aec_poly_step #(.D(SIN_DIVS[i]), .ADD(1'b0)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (cv[i]),
            .x_in      (cx[i]),
            .p_in      (cp[i]),
            .side_in   (cs[i]),
            .out_valid (cv[i+1]),
            .x_out     (cx[i+1]),
            .p_out     (cp[i+1]),
            .side_out  (cs[i+1])
        );
    end

    assign out_valid = vld_reg[2];
    assign sin_q30   = side3_reg.quad[1] ? -32'(prod3_reg[60:30]) : 32'(prod3_reg[60:30]);
    assign side_out  = side3_reg;

endmodule

### hdl/aec_post.sv
`timescale 1ns / 1ps
// Per-curve back end: products, rounding, curve select, saturation, output
// register. Four stages; uses aec_pkg.
module aec_post
    import aec_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  side_t              side_in,
    input  logic signed [31:0] sin_q30,
    output logic               out_valid,
    output logic [OUT_W-1:0]   eased_value
);

    logic [2:0] vld_reg;
    logic       m_valid_reg;

    // stage 1
    logic signed [63:0] vel1_reg;
    logic signed [49:0] w11_reg;
    logic signed [37:0] dd1_reg;
    logic signed [33:0] r21_reg;
    // stage 2
    logic signed [63:0] rs2_reg;
    logic signed [39:0] a2_reg;
    logic signed [39:0] r32_reg;
    logic signed [33:0] r22_reg;
    // stage 3
    logic signed [55:0] w23_reg;
    logic signed [63:0] rel3_reg;
    logic signed [39:0] r33_reg;
    logic signed [33:0] r23_reg;
    // output
    logic [OUT_W-1:0]      eased_reg;
    logic signed [T_W-1:0] t_o_reg;
    logic [KIND_W-1:0]     kind_o_reg;

    logic signed [T_W-1:0] t1_reg, t2_reg, t3_reg;
    logic [KIND_W-1:0]     kind1_reg, kind2_reg, kind3_reg;
    logic signed [5:0]     ip1_reg, ip2_reg;

    logic signed [31:0] osc;
    logic signed [32:0] expv_s;
    logic signed [18:0] d1;
    logic [6:0]         k;
    logic signed [55:0] w1_sh;
    logic signed [55:0] a_full;
    logic signed [39:0] r3;
    logic signed [18:0] omt;
    logic signed [63:0] rel;
    logic signed [55:0] rw;
    logic signed [63:0] r;
    logic [OUT_W-1:0]   sat;

    always_comb begin
        osc    = (is_pulse(side_in.kind) && sin_q30 < 0) ? -sin_q30 : sin_q30;
        expv_s = signed'({1'b0, side_in.expv});
        d1     = T_ONE - 19'(side_in.t);

        k      = 7'(K_BASE) - 7'(ip1_reg);
        w1_sh  = 56'(w11_reg) <<< wave_sh(kind1_reg);
        a_full = (w1_sh + 56'sd32768) >>> FRAC_BITS;
        r3     = (40'sd4294967296 - 40'(dd1_reg) + 40'sd32768) >>> FRAC_BITS;

        omt    = T_ONE - 19'(t2_reg);
        if (t2_reg == 0 || 19'(t2_reg) == T_ONE) begin
            rel = 64'(t2_reg);
        end else if (ip2_reg < 6'(IP_MIN)) begin
            rel = 64'(T_ONE);
        end else begin
            rel = 64'(T_ONE) + rs2_reg;
        end

        rw = (w23_reg + 56'sd1073741824) >>> 31;
        case (kind_t'(kind3_reg))
            K_ONE:     r = 64'(T_ONE);
            K_SINE:    r = 64'(r23_reg);
            K_QUAD:    r = 64'(r33_reg);
            K_ELASTIC: r = rel3_reg;
            K_BOUNCE1, K_BOUNCE2, K_BOUNCE4, K_BOUNCE8, K_PULSE1, K_PULSE8: begin
                r = (t3_reg > 0 && 19'(t3_reg) < T_ONE) ? 64'(rw) : 64'sd0;
            end
            default:   r = 64'(t3_reg);
        endcase
        if (r > OUT_MAX) begin
            sat = OUT_W'(OUT_MAX);
        end else if (r < OUT_MIN) begin
            sat = OUT_W'(OUT_MIN);
        end else begin
            sat = r[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[1:0], in_valid};
            m_valid_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            vel1_reg   <= 64'(expv_s) * 64'(sin_q30);
            w11_reg    <= 50'(osc) * 50'(side_in.t);
            dd1_reg    <= 38'(d1) * 38'(d1);
            r21_reg    <= (34'sd1073741824 - 34'(sin_q30) + 34'sd16384) >>> PH_SH;
            t1_reg     <= side_in.t;
            kind1_reg  <= side_in.kind;
            ip1_reg    <= side_in.ip;

            rs2_reg    <= (vel1_reg + (64'sd1 <<< (k - 7'd1))) >>> k;
            a2_reg     <= a_full[39:0];
            r32_reg    <= r3;
            r22_reg    <= r21_reg;
            t2_reg     <= t1_reg;
            kind2_reg  <= kind1_reg;
            ip2_reg    <= ip1_reg;

            w23_reg    <= 56'(a2_reg) * 56'(omt);
            rel3_reg   <= rel;
            r33_reg    <= r32_reg;
            r23_reg    <= r22_reg;
            t3_reg     <= t2_reg;
            kind3_reg  <= kind2_reg;

            eased_reg  <= sat;
            t_o_reg    <= t3_reg;
            kind_o_reg <= kind3_reg;
        end
    end

    assign out_valid   = m_valid_reg;
    assign eased_value = eased_reg;

    ap_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && kind_o_reg == K_ONE |-> eased_reg == OUT_W'(T_ONE))
        else $error("constant-one curve wrong");

    ap_wave_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && is_wave(kind_o_reg) && (t_o_reg <= 0 || 19'(t_o_reg) >= T_ONE)
        |-> eased_reg == '0)
        else $error("bounce/pulse nonzero outside (0,1)");

    ap_pulse_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (kind_o_reg == K_PULSE1 || kind_o_reg == K_PULSE8)
        |-> !eased_reg[OUT_W-1])
        else $error("pulse curve negative");

endmodule
